[sv/impq_pkg.sv]
package impq_pkg;

	localparam int CAPACITY = 1024;
	localparam int NVERT    = 1024;
	localparam int VTX_W    = 10;
	localparam int POS_W    = $clog2(CAPACITY);
	localparam int CNT_W    = POS_W + 1;
	localparam int KEY_W    = 32;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	typedef enum logic [1:0] {
		REQ_INSERT   = 2'd0,
		REQ_EXTRACT  = 2'd1,
		REQ_DECREASE = 2'd2,
		REQ_LOOKUP   = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		STS_OK      = 3'd0,
		STS_EMPTY   = 3'd1,
		STS_FULL    = 3'd2,
		STS_PRESENT = 3'd3,
		STS_ABSENT  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_CMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		req_type_t               rtype;
		logic [VTX_W-1:0]        vtx;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		status_t                 status;
		logic                    empty;
		logic                    in_heap;
		logic signed [KEY_W-1:0] key;
		logic [VTX_W-1:0]        vtx;
	} res_t;

	// per-vertex record
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [POS_W-1:0]        slot;
		logic                    present;
	} vinfo_t;

	// heap slot holds the vertex and a copy of its key
	typedef struct packed {
		logic [VTX_W-1:0]        vtx;
		logic signed [KEY_W-1:0] key;
	} hent_t;

endpackage

[sv/impq_core.sv]
module impq_core
	import impq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic idle,
	output logic res_valid,
	output res_t res,
	input  logic res_take
);

	vinfo_t vmem_q [NVERT];
	hent_t  hmem_q [CAPACITY];

	state_t state_q, state_d;
	logic [VTX_W-1:0] clr_q, clr_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	req_t req_q, req_d;
	logic [POS_W-1:0] pos_q, pos_d;
	hent_t mv_q, mv_d;
	res_t res_q, res_d;

	logic             vm_we;
	logic [VTX_W-1:0] vm_waddr, vm_raddr;
	vinfo_t           vm_wdata, vm_rd_q;
	logic             hp_we;
	logic [POS_W-1:0] hp_waddr, hp_raddr_a, hp_raddr_b;
	hent_t            hp_wdata, hp_rd_a_q, hp_rd_b_q;

	logic [POS_W-1:0] par;
	logic [CNT_W:0]   lidx, ridx;
	logic             lv, rv, take_l, take_r;
	logic [CNT_W-1:0] cnt_m1;

	always_ff @(posedge clk) begin
		if (vm_we)
			vmem_q[vm_waddr] <= vm_wdata;
		vm_rd_q <= vmem_q[vm_raddr];
	end

	always_ff @(posedge clk) begin
		if (hp_we)
			hmem_q[hp_waddr] <= hp_wdata;
		hp_rd_a_q <= hmem_q[hp_raddr_a];
		hp_rd_b_q <= hmem_q[hp_raddr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q <= req_d;
		pos_q <= pos_d;
		mv_q  <= mv_d;
		res_q <= res_d;
	end

	assign par    = (pos_q - POS_W'(1)) >> 1;
	assign lidx   = {1'b0, pos_q, 1'b1};
	assign ridx   = {1'b0, pos_q, 1'b0} + (CNT_W+1)'(2);
	assign lv     = lidx < {1'b0, cnt_q};
	assign rv     = ridx < {1'b0, cnt_q};
	assign take_l = lv && ($signed(hp_rd_a_q.key) < $signed(mv_q.key));
	assign take_r = rv && (take_l ? ($signed(hp_rd_b_q.key) < $signed(hp_rd_a_q.key))
	                              : ($signed(hp_rd_b_q.key) < $signed(mv_q.key)));
	assign cnt_m1 = cnt_q - CNT_W'(1);

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		cnt_d      = cnt_q;
		req_d      = req_q;
		pos_d      = pos_q;
		mv_d       = mv_q;
		res_d      = res_q;
		vm_we      = 1'b0;
		vm_waddr   = mv_q.vtx;
		vm_wdata   = '{key: mv_q.key, slot: pos_q, present: 1'b1};
		vm_raddr   = req.vtx;
		hp_we      = 1'b0;
		hp_waddr   = pos_q;
		hp_wdata   = mv_q;
		hp_raddr_a = '0;
		hp_raddr_b = cnt_m1[POS_W-1:0];
		idle       = 1'b0;
		res_valid  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				vm_we    = 1'b1;
				vm_waddr = clr_q;
				vm_wdata = '{key: KEY_MAX, slot: '0, present: 1'b0};
				clr_d    = clr_q + VTX_W'(1);
				if (&clr_q)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					req_d   = req;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = ST_FIN;
				res_d   = '{status: STS_OK, empty: (cnt_q == '0), in_heap: vm_rd_q.present,
				            key: vm_rd_q.key, vtx: req_q.vtx};
				mv_d    = '{vtx: req_q.vtx, key: req_q.key};
				case (req_q.rtype)
					REQ_INSERT: begin
						if (vm_rd_q.present) begin
							res_d.status = STS_PRESENT;
						end else if (cnt_q == CAP_CNT) begin
							res_d.status = STS_FULL;
						end else begin
							pos_d         = cnt_q[POS_W-1:0];
							cnt_d         = cnt_q + CNT_W'(1);
							res_d.key     = req_q.key;
							res_d.in_heap = 1'b1;
							res_d.empty   = 1'b0;
							state_d       = ST_UP_RD;
						end
					end
					REQ_DECREASE: begin
						if (!vm_rd_q.present) begin
							res_d.status = STS_ABSENT;
						end else begin
							pos_d     = vm_rd_q.slot;
							res_d.key = req_q.key;
							state_d   = ST_UP_RD;
						end
					end
					REQ_EXTRACT: begin
						if (cnt_q == '0) begin
							res_d.status = STS_EMPTY;
						end else begin
							vm_we         = 1'b1;
							vm_waddr      = hp_rd_a_q.vtx;
							vm_wdata      = '{key: hp_rd_a_q.key, slot: '0, present: 1'b0};
							cnt_d         = cnt_m1;
							res_d.vtx     = hp_rd_a_q.vtx;
							res_d.key     = hp_rd_a_q.key;
							res_d.in_heap = 1'b0;
							res_d.empty   = (cnt_m1 == '0);
							if (cnt_m1 != '0) begin
								mv_d    = hp_rd_b_q;
								pos_d   = '0;
								state_d = ST_DN_RD;
							end
						end
					end
					default: ;
				endcase
			end
			ST_UP_RD: begin
				hp_raddr_a = par;
				if (pos_q == '0) begin
					hp_we   = 1'b1;
					vm_we   = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				hp_we = 1'b1;
				vm_we = 1'b1;
				if ($signed(mv_q.key) < $signed(hp_rd_a_q.key)) begin
					hp_wdata = hp_rd_a_q;
					vm_waddr = hp_rd_a_q.vtx;
					vm_wdata = '{key: hp_rd_a_q.key, slot: pos_q, present: 1'b1};
					pos_d    = par;
					state_d  = ST_UP_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DN_RD: begin
				hp_raddr_a = lidx[POS_W-1:0];
				hp_raddr_b = ridx[POS_W-1:0];
				state_d    = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				hp_we = 1'b1;
				vm_we = 1'b1;
				if (take_r) begin
					hp_wdata = hp_rd_b_q;
					vm_waddr = hp_rd_b_q.vtx;
					vm_wdata = '{key: hp_rd_b_q.key, slot: pos_q, present: 1'b1};
					pos_d    = ridx[POS_W-1:0];
					state_d  = ST_DN_RD;
				end else if (take_l) begin
					hp_wdata = hp_rd_a_q;
					vm_waddr = hp_rd_a_q.vtx;
					vm_wdata = '{key: hp_rd_a_q.key, slot: pos_q, present: 1'b1};
					pos_d    = lidx[POS_W-1:0];
					state_d  = ST_DN_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				res_valid = 1'b1;
				if (res_take)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res = res_q;

endmodule

[sv/indexed_min_priority_queue.sv]
// Indexed binary min-heap, one transaction at a time.
// Lookup and rejected requests pass through the LOOK and FIN states only; a sift adds a read
// state and a compare state per level of the heap, over at most 10 levels.
// The next transaction is accepted only after the last one is through: s_tready returns in the
// same cycle as the result reaches the output register, and a stalled output holds the input off.
// Reset: asynchronous, active low; a pass over all 1024 vertex records then clears the
// per-vertex memory before s_tready rises.
module indexed_min_priority_queue
	import impq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // vertex[9:0], key[41:10], zero fill
	input  logic [1:0]  s_tuser,  // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // out_vertex[9:0], out_key[41:10], in_heap[42],
	                              // heap_empty[43], status[46:44], zero fill
);

	logic  start, idle, res_valid, res_take;
	req_t  req;
	res_t  res;
	logic  m_tvalid_q;
	res_t  m_res_q;

	assign req      = '{rtype: req_type_t'(s_tuser), vtx: s_tdata[9:0], key: s_tdata[41:10]};
	assign s_tready = idle;
	assign start    = s_tvalid && idle;
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	impq_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take)
			m_res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_res_q};

endmodule
